// ===== src/assert_macros.svh =====
// Assertion macros for the radix-2 FFT block.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPLY(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== src/fft_pkg.sv =====
// Shared types and constants for the radix-2 FFT block.
// No dependencies.
package fft_pkg;
  localparam int POINTS = 16;
  localparam int STAGES = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_W = SAMPLE_BITS;
  localparam int BIN_W = SAMPLE_BITS + STAGES;
  localparam int IDX_W = STAGES;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic frame_end;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic signed [BIN_W-1:0] bin_re;
    logic signed [BIN_W-1:0] bin_im;
    logic bin_last;
  } bin_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD_A, ST_RD_B, ST_MUL, ST_WR, ST_OUT_RD, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_a;
    logic rd_b;
    logic mul;
    logic wr;
    logic out_rd;
  } cmd_t;

  // quarter cosine, Q1.15 with unity 32768
  function automatic logic signed [17:0] cos_q(input logic [4:0] r);
    case (r)
      5'd0: cos_q = 18'sd32768;  5'd1: cos_q = 18'sd32610;
      5'd2: cos_q = 18'sd32138;  5'd3: cos_q = 18'sd31357;
      5'd4: cos_q = 18'sd30274;  5'd5: cos_q = 18'sd28899;
      5'd6: cos_q = 18'sd27246;  5'd7: cos_q = 18'sd25330;
      5'd8: cos_q = 18'sd23170;  5'd9: cos_q = 18'sd20788;
      5'd10: cos_q = 18'sd18205; 5'd11: cos_q = 18'sd15447;
      5'd12: cos_q = 18'sd12540; 5'd13: cos_q = 18'sd9512;
      5'd14: cos_q = 18'sd6393;  5'd15: cos_q = 18'sd3212;
      default: cos_q = 18'sd0;
    endcase
  endfunction

  function automatic logic signed [17:0] rom_cos(input logic [5:0] t);
    logic [1:0] q;
    logic [4:0] r;
    q = t[5:4];
    r = {1'b0, t[3:0]};
    case (q)
      2'd0: rom_cos = cos_q(r);
      2'd1: rom_cos = -cos_q(5'd16 - r);
      2'd2: rom_cos = -cos_q(r);
      default: rom_cos = cos_q(5'd16 - r);
    endcase
  endfunction
endpackage

// ===== src/radix2_fft.sv =====
// Radix-2 FFT, fft_pkg::POINTS complex samples, decimation in frequency.
// Load: one sample per cycle while in the load state. Transform: each butterfly steps
// through read A, read B, multiply and write states over a shared butterfly unit,
// POINTS/2*STAGES butterflies; unload: each bin is read, registered and offered until taken.
// One frame at a time: no new sample is taken until the last bin of the frame is taken.
// Synchronous active-high reset clears control and sets direction to forward.
`include "assert_macros.svh"
module radix2_fft (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  fft_pkg::sample_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output fft_pkg::bin_t out_data
);
  logic direction;
  fft_pkg::cmd_t cmd;
  logic [$clog2(fft_pkg::STAGES)-1:0] stage;
  logic [fft_pkg::STAGES-2:0] bfly;
  logic [fft_pkg::STAGES-1:0] bin;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) direction <= 1'b0;
    else if (cfg_valid) direction <= cfg_data;
  end

  fft_ctrl u_ctrl (
    .clk, .rst, .in_valid, .frame_end(in_data.frame_end),
    .out_busy(out_valid && !out_ready), .out_taken(out_valid && out_ready),
    .in_ready, .cmd, .stage, .bfly, .bin
  );

  fft_dp u_dp (
    .clk, .rst, .cmd, .stage, .bfly, .bin, .direction,
    .sample(in_data), .result(out_data), .out_valid, .out_ready
  );

  `ASSERT_IMPLY(a_no_in_when_out, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_last_ends, clk, rst, out_valid && out_ready && out_data.bin_last, !out_valid)
  `ASSERT_IMPLY(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))
endmodule

// ===== src/fft_ctrl.sv =====
// Sequencer of the radix-2 FFT: load, butterfly stages, unload.
// Depends on fft_pkg.
module fft_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic frame_end,
  input  logic out_busy,
  input  logic out_taken,
  output logic in_ready,
  output fft_pkg::cmd_t cmd,
  output logic [$clog2(fft_pkg::STAGES)-1:0] stage,
  output logic [fft_pkg::STAGES-2:0] bfly,
  output logic [fft_pkg::STAGES-1:0] bin
);
  localparam int STAGES = fft_pkg::STAGES;
  localparam int SW = $clog2(STAGES);
  fft_pkg::state_t state, state_next;
  logic last_bfly, last_stage, last_bin;

  assign last_bfly = (bfly == {(STAGES-1){1'b1}});
  assign last_stage = (stage == SW'(STAGES-1));
  assign last_bin = (bin == {STAGES{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fft_pkg::ST_LOAD;
      stage <= '0;
      bfly <= '0;
      bin <= '0;
    end else begin
      state <= state_next;
      if (state == fft_pkg::ST_WR) begin
        bfly <= bfly + 1'b1;
        if (last_bfly) stage <= last_stage ? '0 : stage + 1'b1;
      end
      if (state == fft_pkg::ST_OUT && out_taken) bin <= bin + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fft_pkg::ST_LOAD: if (in_valid && frame_end) state_next = fft_pkg::ST_RD_A;
      fft_pkg::ST_RD_A: state_next = fft_pkg::ST_RD_B;
      fft_pkg::ST_RD_B: state_next = fft_pkg::ST_MUL;
      fft_pkg::ST_MUL: state_next = fft_pkg::ST_WR;
      fft_pkg::ST_WR: begin
        if (last_bfly && last_stage) state_next = fft_pkg::ST_OUT_RD;
        else state_next = fft_pkg::ST_RD_A;
      end
      fft_pkg::ST_OUT_RD: if (!out_busy) state_next = fft_pkg::ST_OUT;
      fft_pkg::ST_OUT: begin
        if (out_taken) state_next = last_bin ? fft_pkg::ST_LOAD : fft_pkg::ST_OUT_RD;
      end
      default: state_next = fft_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      fft_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fft_pkg::ST_RD_A: cmd.rd_a = 1'b1;
      fft_pkg::ST_RD_B: cmd.rd_b = 1'b1;
      fft_pkg::ST_MUL: cmd.mul = 1'b1;
      fft_pkg::ST_WR: cmd.wr = 1'b1;
      fft_pkg::ST_OUT_RD: cmd.out_rd = !out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

// ===== src/fft_dp.sv =====
// Datapath of the radix-2 FFT: sample store, work memory, butterfly, output register.
// Depends on fft_pkg.
module fft_dp (
  input  logic clk,
  input  logic rst,
  input  fft_pkg::cmd_t cmd,
  input  logic [$clog2(fft_pkg::STAGES)-1:0] stage,
  input  logic [fft_pkg::STAGES-2:0] bfly,
  input  logic [fft_pkg::STAGES-1:0] bin,
  input  logic direction,
  input  fft_pkg::sample_t sample,
  output fft_pkg::bin_t result,
  output logic out_valid,
  input  logic out_ready
);
  localparam int POINTS = fft_pkg::POINTS;
  localparam int STAGES = fft_pkg::STAGES;
  localparam int SAMPLE_BITS = fft_pkg::SAMPLE_BITS;
  localparam int AW = STAGES;
  localparam int OW = SAMPLE_BITS + STAGES;
  localparam int PW = OW + 19;
  localparam int ROM_STEP = 64 / POINTS;

  logic signed [SAMPLE_BITS-1:0] st_re [POINTS];
  logic signed [SAMPLE_BITS-1:0] st_im [POINTS];
  logic signed [OW-1:0] wk_re [POINTS];
  logic signed [OW-1:0] wk_im [POINTS];
  logic [POINTS-1:0] wk_src; // 1: entry has been written in this transform
  logic [AW-1:0] load_count;

  logic signed [OW-1:0] a_re, a_im, b_re, b_im, d_re, d_im;
  logic signed [OW-1:0] rd_re, rd_im, st_rre, st_rim;
  logic signed [17:0] w_re, w_im;
  logic signed [PW-1:0] p_re, p_im;
  logic [AW-1:0] ia, ib, rd_addr, rev;
  logic [AW-1:0] half;
  logic [5:0] t;
  logic out_rd_d;

  // group index in high bits above the stage bit, member index below
  always_comb begin
    logic [AW-1:0] m, g;
    half = AW'(POINTS >> (stage + 1));
    m = AW'(bfly) & (half - 1'b1);
    g = (AW'(bfly) & ~(half - 1'b1)) << 1;
    ia = g | m;
    ib = ia | half;
    t = 6'((32'(m) << stage) * ROM_STEP);
    for (int k = 0; k < AW; k++) rev[k] = bin[AW-1-k];
  end

  assign rd_addr = cmd.rd_a ? ia : cmd.rd_b ? ib : rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      wk_src <= '0;
      out_valid <= 1'b0;
      out_rd_d <= 1'b0;
    end else begin
      out_rd_d <= cmd.out_rd;
      if (cmd.load) begin
        load_count <= sample.frame_end ? '0 : load_count + 1'b1;
        if (sample.frame_end) wk_src <= '0;
      end
      if (cmd.wr) begin
        wk_src[ia] <= 1'b1;
        wk_src[ib] <= 1'b1;
      end
      if (out_rd_d) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_re[load_count] <= sample.sample_re;
      st_im[load_count] <= sample.sample_im;
    end
    rd_re <= wk_re[rd_addr];
    rd_im <= wk_im[rd_addr];
    st_rre <= OW'(st_re[rd_addr]);
    st_rim <= OW'(st_im[rd_addr]);
    if (cmd.wr) begin
      wk_re[ia] <= a_re + b_re;
      wk_im[ia] <= a_im + b_im;
      wk_re[ib] <= OW'((p_re + PW'(16384)) >>> 15);
      wk_im[ib] <= OW'((p_im + PW'(16384)) >>> 15);
    end
  end

  logic sel_wk;
  always_ff @(posedge clk) sel_wk <= wk_src[rd_addr];

  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      a_re <= sel_wk ? rd_re : st_rre;
      a_im <= sel_wk ? rd_im : st_rim;
    end
    if (cmd.mul) begin
      b_re <= sel_wk ? rd_re : st_rre;
      b_im <= sel_wk ? rd_im : st_rim;
      w_re <= fft_pkg::rom_cos(t);
      w_im <= direction ? fft_pkg::rom_cos(t + 6'd48) : -fft_pkg::rom_cos(t + 6'd48);
    end
    if (out_rd_d) begin
      result.bin_index <= bin;
      result.bin_re <= sel_wk ? rd_re : st_rre;
      result.bin_im <= sel_wk ? rd_im : st_rim;
      result.bin_last <= (bin == {AW{1'b1}});
    end
  end

  assign d_re = a_re - b_re;
  assign d_im = a_im - b_im;
  assign p_re = PW'(d_re) * PW'(w_re) - PW'(d_im) * PW'(w_im);
  assign p_im = PW'(d_im) * PW'(w_re) + PW'(d_re) * PW'(w_im);
endmodule

// ===== sim/tb_radix2_fft.sv =====
// Self-checking testbench for the 16-point radix-2 FFT block radix2_fft.
// Depends on fft_pkg for the sample and bin types; predicts bins in-line.
module tb_radix2_fft;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 16;
  localparam int NSTG = 4;
  localparam int LIMIT = 2000000;

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  fft_pkg::sample_t in_data;
  fft_pkg::bin_t out_data;

  radix2_fft dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic signed [15:0] pt_re[NPTS];
  logic signed [15:0] pt_im[NPTS];
  int load_ptr;
  bit inverse;
  fft_pkg::bin_t bins_due[$];
  int errors, mismatches;
  int cycles;
  int hold_cycles;
  int rx_wait;
  bit stall_rand;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint q_cos(int t);
    int q, r;
    longint c[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                      20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    t = t & 63;
    q = t >> 4;
    r = t & 15;
    case (q)
      0: return c[r];
      1: return -c[16 - r];
      2: return -c[r];
      default: return c[16 - r];
    endcase
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  task automatic transform_frame();
    longint xr[NPTS], xi[NPTS];
    longint wr, wi, dr, di;
    int half, ia, ib, t, src;
    fft_pkg::bin_t b;
    for (int k = 0; k < NPTS; k++) begin
      xr[k] = pt_re[k];
      xi[k] = pt_im[k];
    end
    for (int s = 0; s < NSTG; s++) begin
      half = NPTS >> (s + 1);
      for (int g = 0; g < NPTS; g += 2 * half)
        for (int m = 0; m < half; m++) begin
          ia = g + m;
          ib = ia + half;
          t = ((m << s) * (64 / NPTS)) & 63;
          wr = q_cos(t);
          wi = inverse ? q_cos(t + 48) : -q_cos(t + 48);
          dr = xr[ia] - xr[ib];
          di = xi[ia] - xi[ib];
          xr[ia] = xr[ia] + xr[ib];
          xi[ia] = xi[ia] + xi[ib];
          xr[ib] = round_q15(dr * wr - di * wi);
          xi[ib] = round_q15(di * wr + dr * wi);
        end
    end
    for (int k = 0; k < NPTS; k++) begin
      src = int'({k[0], k[1], k[2], k[3]});
      b.bin_index = k[3:0];
      b.bin_re = xr[src][19:0];
      b.bin_im = xi[src][19:0];
      b.bin_last = (k == NPTS - 1);
      bins_due.push_back(b);
    end
  endtask

  // Send one sample request and update the prediction when accepted.
  // Valid stays high after acceptance until the next request or an idle drop.
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, bit last);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= '{sample_re: re, sample_im: im, frame_end: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pt_re[load_ptr] = re;
    pt_im[load_ptr] = im;
    load_ptr = (load_ptr + 1) % NPTS;
    if (last) begin
      load_ptr = 0;
      transform_frame();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_direction(bit dir);
    cfg_data <= dir;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    inverse = dir;
  endtask

  function automatic logic signed [15:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int len);
    for (int i = 0; i < len; i++)
      send_sample(rnd_val(), rnd_val(), i == len - 1);
  endtask

  // Directed: full-scale impulse forward, then extremes and a constant inverse.
  task automatic test_directed();
    for (int i = 0; i < NPTS; i++)
      send_sample(i == 0 ? 16'sh7fff : 16'sh0, i == 0 ? 16'sh8000 : 16'sh0, i == NPTS - 1);
    drain();
    set_direction(1'b1);
    for (int i = 0; i < NPTS; i++)
      send_sample(i[0] ? 16'sh8000 : 16'sh7fff, 16'sh7fff, i == NPTS - 1);
    drain();
    set_direction(1'b0);
  endtask

  // Short frames keep older samples; long frames wrap over the oldest.
  task automatic test_frame_lengths();
    send_frame(5);
    send_frame(NPTS + 3);
    drain();
  endtask

  task automatic test_random_frames();
    for (int f = 0; f < 18; f++) begin
      if (f % 6 == 5) begin
        drain();
        set_direction(1'($urandom_range(0, 1)));
      end
      send_frame($urandom_range(0, 4) == 0 ? $urandom_range(1, 24) : NPTS);
    end
    drain();
  endtask

  // Hold off the receiver while frames keep arriving, so the input stalls.
  task automatic test_backpressure();
    hold_cycles = 600;
    send_frame(NPTS);
    send_frame(NPTS);
    drain();
  endtask

  // Receiver: with stall_rand set, draw a wait for each bin taken and hold ready low for it.
  always @(posedge clk) begin : rx_side
    int draw;
    draw = 0;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (stall_rand) draw = $urandom_range(0, 19);
      rx_wait <= draw;
      out_ready <= (draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected bin %p", out_data);
      end else if (out_data !== bins_due[0]) begin
        errors++;
        if (mismatches++ < 10)
          $display("bin mismatch: expected %p got %p", bins_due[0], out_data);
        void'(bins_due.pop_front());
      end else begin
        void'(bins_due.pop_front());
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cycles = 0;
    hold_cycles = 0;
    stall_rand = 1'b0;
    errors = 0;
    mismatches = 0;
    load_ptr = 0;
    inverse = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_direction(1'b0);
    test_directed();
    test_frame_lengths();
    stall_rand = 1'b1;
    test_random_frames();
    test_backpressure();
    if (errors == 0 && bins_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/fft_pkg.sv
src/fft_ctrl.sv
src/fft_dp.sv
src/radix2_fft.sv
sim/tb_radix2_fft.sv
